FILE: rtl/caf_pkg.sv
// shared types, constants and arithmetic helpers of the complementary attitude filter
`default_nettype none
package caf_pkg;

  // datapath widths
  localparam int XW = 44;            // cordic vector components
  localparam int ZW = 34;            // cordic angle accumulator, q28 radians
  localparam int AW = 34;            // signed multiplicand of the digit multiplier
  localparam int BW = 24;            // unsigned multiplier operand
  localparam int PW = 60;            // product and blend sum
  localparam int MUL_DIGITS = BW / 4;
  localparam int ACC_W = 26;         // accel angle, q16 degrees
  localparam int HG_W = 29;          // h * rate, q16 degrees
  localparam int SQ_W = 48;          // radicand of the square root

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam logic [BW-1:0] DEG_PER_RAD_Q16 = 24'd3756841;

  // register reset values and indexes
  localparam logic [15:0] GAMMA_RST = 16'd62259;
  localparam logic [15:0] STEP_RST = 16'd655;
  localparam logic [7:0] CFG_GAMMA = 8'd0;
  localparam logic [7:0] CFG_STEP = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_AY, ST_SQ_AZ, ST_SQRT, ST_CPRE, ST_CITER, ST_DEG,
    ST_HX, ST_HY, ST_HZ, ST_ROLL_W, ST_ROLL_G, ST_PITCH_W, ST_PITCH_G,
    ST_YAW_G, ST_DONE
  } caf_state_t;

  // atan(2^-i) in q28 radians, zero past the table
  function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 34'sd210828714;
      5'd1:  v = 34'sd124459457;
      5'd2:  v = 34'sd65760959;
      5'd3:  v = 34'sd33381290;
      5'd4:  v = 34'sd16755422;
      5'd5:  v = 34'sd8385879;
      5'd6:  v = 34'sd4193963;
      5'd7:  v = 34'sd2097109;
      5'd8:  v = 34'sd1048571;
      5'd9:  v = 34'sd524287;
      5'd10: v = 34'sd262144;
      5'd11: v = 34'sd131072;
      5'd12: v = 34'sd65536;
      5'd13: v = 34'sd32768;
      5'd14: v = 34'sd16384;
      5'd15: v = 34'sd8192;
      5'd16: v = 34'sd4096;
      5'd17: v = 34'sd2048;
      5'd18: v = 34'sd1024;
      5'd19: v = 34'sd512;
      5'd20: v = 34'sd256;
      5'd21: v = 34'sd128;
      5'd22: v = 34'sd64;
      5'd23: v = 34'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up by 16 bits, saturate to signed 32
  function automatic logic signed [31:0] rnd16_sat32(input logic signed [PW-1:0] s);
    logic signed [PW-1:0] t;
    t = (s + PW'(32768)) >>> 16;
    if (t > PW'(2147483647)) return 32'(PW'(2147483647));
    if (t < -PW'(2147483647) - PW'(1)) return 32'(-PW'(2147483647) - PW'(1));
    return 32'(t);
  endfunction

  // saturating add of estimate and gyro increment
  function automatic logic signed [31:0] add_sat32(input logic signed [31:0] a,
                                                   input logic signed [HG_W-1:0] b);
    logic signed [33:0] t;
    t = 34'(a) + 34'(b);
    if (t > 34'(2147483647)) return 32'(34'(2147483647));
    if (t < -34'(2147483647) - 34'(1)) return 32'(-34'(2147483647) - 34'(1));
    return 32'(t);
  endfunction

  // estimate to 1/256 degree, round half up, saturate to 24 bits
  function automatic logic [23:0] to_out(input logic signed [31:0] e);
    logic signed [33:0] t;
    t = (34'(e) + 34'(128)) >>> 8;
    if (t > 34'(8388607)) return 24'(34'(8388607));
    if (t < 34'(-8388608)) return 24'(34'(-8388608));
    return 24'(t);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/caf_digit_mul.sv
// signed by unsigned multiplier, one 4 bit digit of the multiplier per cycle
`default_nettype none
module caf_digit_mul import caf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 run,
  input  wire logic signed [AW-1:0] a,
  input  wire logic        [BW-1:0] b,
  output logic                      last,
  output logic signed [PW-1:0]      prod
);

  logic [2:0]           cnt_r, cnt_nxt;
  logic signed [PW-1:0] acc_r;
  logic [BW-1:0]        b_sh;
  logic [3:0]           dig;
  logic signed [AW+4:0] term;
  logic signed [PW-1:0] base;

  // msb digit first: acc = acc * 16 + a * digit
  always_comb begin
    b_sh = b << (4 * cnt_r);
    dig = b_sh[BW-1 -: 4];
    term = a * $signed({1'b0, dig});
    base = (cnt_r == 3'd0) ? '0 : (acc_r <<< 4);
    prod = base + PW'(term);
    last = run && (cnt_r == 3'(MUL_DIGITS - 1));
    cnt_nxt = (run && !last) ? cnt_r + 3'd1 : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (run) begin
      acc_r <= prod;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/complementary_attitude_filter_core.sv
// top level of the complementary attitude filter
`default_nettype none
// One IMU sample in, one roll/pitch/yaw estimate out. The block works on one
// sample at a time. Each all-zero vector skips its CORDIC iterations, so roll
// skips them when accel y and z are both zero, and pitch skips them when all
// three accel readings are zero. A result still stalled in the output
// register holds the next one back. The block is ready again the cycle after
// a result is loaded into the output register, while that result waits to be
// taken. The work for each sample is:
//   - the shared 4 bit digit multiplier: twelve products
//   - the square root: one result bit a cycle
//   - a pre-rotation of each of the roll and pitch vectors
//   - one CORDIC iteration a cycle for each of the roll and pitch angles
//   - the load of the output register
// Configuration writes are always accepted.
module complementary_attitude_filter_core import caf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic signed [15:0] in_rate_x,
  input  wire logic signed [15:0] in_rate_y,
  input  wire logic signed [15:0] in_rate_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [23:0]      out_roll_out,
  output logic signed [23:0]      out_pitch_out,
  output logic signed [23:0]      out_yaw_out,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  caf_state_t state_r, state_nxt;

  logic [15:0] gamma_r, step_r;
  logic signed [15:0] ax_r, ay_r, az_r, rx_r, ry_r, rz_r;
  logic [31:0] sqa_r;
  logic [SQ_W-1:0] sq_n_r, sq_q_r, sq_bit_r;
  logic [23:0] sqrt_r;
  logic signed [XW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [IW-1:0] it_r;
  logic pitch_r;
  logic signed [ACC_W-1:0] roll_acc_r, pitch_acc_r;
  logic signed [HG_W-1:0] hx_r, hy_r, hz_r;
  logic signed [PW-1:0] wsum_r;
  logic signed [31:0] roll_est_r, pitch_est_r, yaw_est_r;
  logic out_valid_r;
  logic signed [23:0] roll_o_r, pitch_o_r, yaw_o_r;

  logic mul_run, mul_last;
  logic signed [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_prod;

  logic [SQ_W-1:0] sq_try;
  logic sq_ge;
  logic signed [XW-1:0] vx, vy, px, py, dx, dy;
  logic signed [ZW-1:0] pz, at;
  logic vzero, it_last, out_load;

  assign in_ready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_roll_out = roll_o_r;
  assign out_pitch_out = pitch_o_r;
  assign out_yaw_out = yaw_o_r;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // shared multiplier and its operand selection
  always_comb begin
    mul_run = 1'b1;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ_AY: begin
        mul_a = AW'(ay_r[15] ? -17'(ay_r) : 17'(ay_r));
        mul_b = BW'(ay_r[15] ? -17'(ay_r) : 17'(ay_r));
      end
      ST_SQ_AZ: begin
        mul_a = AW'(az_r[15] ? -17'(az_r) : 17'(az_r));
        mul_b = BW'(az_r[15] ? -17'(az_r) : 17'(az_r));
      end
      ST_DEG: begin
        mul_a = AW'(cz_r);
        mul_b = DEG_PER_RAD_Q16;
      end
      ST_HX: begin
        mul_a = AW'(rx_r);
        mul_b = BW'(step_r);
      end
      ST_HY: begin
        mul_a = AW'(ry_r);
        mul_b = BW'(step_r);
      end
      ST_HZ: begin
        mul_a = AW'(rz_r);
        mul_b = BW'(step_r);
      end
      ST_ROLL_W: begin
        mul_a = AW'(roll_acc_r);
        mul_b = BW'(17'd65536 - {1'b0, gamma_r});
      end
      ST_PITCH_W: begin
        mul_a = AW'(pitch_acc_r);
        mul_b = BW'(17'd65536 - {1'b0, gamma_r});
      end
      ST_ROLL_G: begin
        mul_a = AW'(roll_est_r) + AW'(hx_r);
        mul_b = BW'(gamma_r);
      end
      ST_PITCH_G: begin
        mul_a = AW'(pitch_est_r) + AW'(hy_r);
        mul_b = BW'(gamma_r);
      end
      ST_YAW_G: begin
        mul_a = AW'(yaw_est_r) + AW'(hz_r);
        mul_b = BW'(gamma_r);
      end
      default: mul_run = 1'b0;
    endcase
  end

  caf_digit_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .run   (mul_run),
    .a     (mul_a),
    .b     (mul_b),
    .last  (mul_last),
    .prod  (mul_prod)
  );

  // square root step, one result bit per cycle
  always_comb begin
    sq_try = sq_q_r + sq_bit_r;
    sq_ge = (sq_n_r >= sq_try);
  end

  // cordic pre-rotation and iteration
  always_comb begin
    if (pitch_r) begin
      vy = -(XW'(ax_r) <<< 24);
      vx = $signed(XW'({sqrt_r, 16'b0}));
    end else begin
      vy = XW'(ay_r) <<< 24;
      vx = XW'(az_r) <<< 24;
    end
    vzero = (vx == '0) && (vy == '0);
    px = vx;
    py = vy;
    pz = '0;
    if (vx < 0) begin
      if (vy >= 0) begin
        px = vy;
        py = -vx;
        pz = atan_q28(5'd0) <<< 1;
      end else begin
        px = -vy;
        py = vx;
        pz = -(atan_q28(5'd0) <<< 1);
      end
    end
    dx = cy_r >>> it_r;
    dy = cx_r >>> it_r;
    at = atan_q28(5'(it_r));
    it_last = (it_r == IW'(CORDIC_STEPS - 1));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_SQ_AY;
      ST_SQ_AY:   if (mul_last) state_nxt = ST_SQ_AZ;
      ST_SQ_AZ:   if (mul_last) state_nxt = ST_SQRT;
      ST_SQRT:    if (sq_bit_r[0]) state_nxt = ST_CPRE;
      ST_CPRE:    state_nxt = vzero ? ST_DEG : ST_CITER;
      ST_CITER:   if (it_last) state_nxt = ST_DEG;
      ST_DEG:     if (mul_last) state_nxt = pitch_r ? ST_HX : ST_CPRE;
      ST_HX:      if (mul_last) state_nxt = ST_HY;
      ST_HY:      if (mul_last) state_nxt = ST_HZ;
      ST_HZ:      if (mul_last) state_nxt = ST_ROLL_W;
      ST_ROLL_W:  if (mul_last) state_nxt = ST_ROLL_G;
      ST_ROLL_G:  if (mul_last) state_nxt = ST_PITCH_W;
      ST_PITCH_W: if (mul_last) state_nxt = ST_PITCH_G;
      ST_PITCH_G: if (mul_last) state_nxt = ST_YAW_G;
      ST_YAW_G:   if (mul_last) state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers: config, estimates, output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RST;
      step_r <= STEP_RST;
      roll_est_r <= '0;
      pitch_est_r <= '0;
      yaw_est_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_GAMMA) gamma_r <= cfg_data;
        if (cfg_index == CFG_STEP) step_r <= cfg_data;
      end
      if (mul_last) begin
        if (state_r == ST_ROLL_G) roll_est_r <= rnd16_sat32(wsum_r + mul_prod);
        if (state_r == ST_PITCH_G) pitch_est_r <= rnd16_sat32(wsum_r + mul_prod);
        if (state_r == ST_YAW_G) yaw_est_r <= add_sat32(rnd16_sat32(mul_prod), hz_r);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      rx_r <= in_rate_x;
      ry_r <= in_rate_y;
      rz_r <= in_rate_z;
      pitch_r <= 1'b0;
    end
    if (out_load) begin
      roll_o_r <= to_out(roll_est_r);
      pitch_o_r <= to_out(pitch_est_r);
      yaw_o_r <= to_out(yaw_est_r);
    end
    case (state_r) inside
      ST_SQ_AY: if (mul_last) sqa_r <= 32'(mul_prod);
      ST_SQ_AZ: begin
        if (mul_last) begin
          sq_n_r <= {sqa_r + 32'(mul_prod), 16'b0};
          sq_q_r <= '0;
          sq_bit_r <= SQ_W'(1) << (SQ_W - 2);
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sq_n_r <= sq_n_r - sq_try;
          sq_q_r <= (sq_q_r >> 1) + sq_bit_r;
        end else begin
          sq_q_r <= sq_q_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        if (sq_bit_r[0]) sqrt_r <= sq_ge ? 24'((sq_q_r >> 1) + sq_bit_r) : 24'(sq_q_r >> 1);
      end
      ST_CPRE: begin
        cx_r <= px;
        cy_r <= py;
        cz_r <= vzero ? '0 : pz;
        it_r <= '0;
      end
      ST_CITER: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + at;
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - at;
        end
        it_r <= it_r + IW'(1);
      end
      ST_DEG: begin
        if (mul_last) begin
          if (pitch_r) pitch_acc_r <= ACC_W'((mul_prod + PW'(134217728)) >>> 28);
          else roll_acc_r <= ACC_W'((mul_prod + PW'(134217728)) >>> 28);
          pitch_r <= 1'b1;
        end
      end
      ST_HX: if (mul_last) hx_r <= HG_W'((mul_prod + PW'(8)) >>> 4);
      ST_HY: if (mul_last) hy_r <= HG_W'((mul_prod + PW'(8)) >>> 4);
      ST_HZ: if (mul_last) hz_r <= HG_W'((mul_prod + PW'(8)) >>> 4);
      ST_ROLL_W, ST_PITCH_W: if (mul_last) wsum_r <= mul_prod;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/caf_checker.sv
// port level checks of the complementary attitude filter
`default_nettype none
module caf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic signed [23:0] out_roll_out,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_roll_out))
    else $error("result dropped while stalled");

  // an input transfer makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a new result appears only after a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without work");

  // configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind complementary_attitude_filter_core caf_checker u_caf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_roll_out (out_roll_out),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);
`default_nettype wire

FILE: verif/complementary_attitude_filter_core_tb.sv
// self-checking testbench of the complementary attitude filter core
module complementary_attitude_filter_core_tb import caf_pkg::*; ();

  // expected attitude tracking and result comparison
  class attitude_tracker;
    typedef struct {
      logic signed [23:0] roll;
      logic signed [23:0] pitch;
      logic signed [23:0] yaw;
    } euler_out_t;

    euler_out_t pending_attitudes[$];
    logic [15:0] gamma_w;
    logic [15:0] step_h;
    int roll_q16;
    int pitch_q16;
    int yaw_q16;
    longint atan_tab[24];
    int mismatches;
    int samples;
    int estimates;

    function new();
      atan_tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                   4193963, 2097109, 1048571, 524287, 262144, 131072,
                   65536, 32768, 16384, 8192, 4096, 2048,
                   1024, 512, 256, 128, 64, 32};
      gamma_w = GAMMA_RST;
      step_h = STEP_RST;
      roll_q16 = 0;
      pitch_q16 = 0;
      yaw_q16 = 0;
      mismatches = 0;
      samples = 0;
      estimates = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] data);
      if (idx == CFG_GAMMA) gamma_w = data;
      else if (idx == CFG_STEP) step_h = data;
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // vectoring cordic, result in q16 degrees at the 180/3.14 scale
    function longint angle_deg(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 2 * atan_tab[0];
        end else begin
          t = x; x = -y; y = t; z = -2 * atan_tab[0];
        end
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_ENTRIES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += atan_tab[i];
        end else begin
          x -= dx; y += dy; z -= atan_tab[i];
        end
      end
      return round_shift(z * 64'sd3756841, 28);
    endfunction

    function int blend_est(int est, longint acc, longint hg);
      longint g, sum;
      g = gamma_w;
      sum = (64'sd65536 - g) * acc + g * (longint'(est) + hg);
      return int'(clamp(round_shift(sum, 16), -64'sd2147483648, 64'sd2147483647));
    endfunction

    function logic signed [23:0] deg256(int est);
      return 24'(clamp(round_shift(longint'(est), 8), -64'sd8388608, 64'sd8388607));
    endfunction

    // accepted sample: advance the estimates and queue the expected attitude
    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic signed [15:0] rx,
                              logic signed [15:0] ry, logic signed [15:0] rz);
      longint h, hx, hy, hz, r, roll_acc, pitch_acc;
      longint unsigned mag2;
      int y;
      euler_out_t a;
      h = step_h;
      hx = round_shift(longint'(rx) * h, 4);
      hy = round_shift(longint'(ry) * h, 4);
      hz = round_shift(longint'(rz) * h, 4);
      mag2 = longint'(longint'(ay) * ay + longint'(az) * az) << 16;
      r = int_sqrt(mag2);
      roll_acc = angle_deg(longint'(ay) <<< 24, longint'(az) <<< 24);
      pitch_acc = angle_deg(-(longint'(ax) <<< 24), r <<< 16);
      roll_q16 = blend_est(roll_q16, roll_acc, hx);
      pitch_q16 = blend_est(pitch_q16, pitch_acc, hy);
      y = blend_est(yaw_q16, 0, hz);
      yaw_q16 = int'(clamp(longint'(y) + hz, -64'sd2147483648, 64'sd2147483647));
      a.roll = deg256(roll_q16);
      a.pitch = deg256(pitch_q16);
      a.yaw = deg256(yaw_q16);
      pending_attitudes.push_back(a);
      samples++;
    endfunction

    function void check_estimate(logic signed [23:0] roll, logic signed [23:0] pitch,
                                 logic signed [23:0] yaw);
      euler_out_t a;
      estimates++;
      if (pending_attitudes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: roll %0d pitch %0d yaw %0d",
                   roll, pitch, yaw);
        return;
      end
      a = pending_attitudes.pop_front();
      if (roll !== a.roll || pitch !== a.pitch || yaw !== a.yaw) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   estimates, a.roll, a.pitch, a.yaw, roll, pitch, yaw);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z;
  logic signed [15:0] in_rate_x, in_rate_y, in_rate_z;
  logic out_valid;
  logic out_ready;
  logic signed [23:0] out_roll_out, out_pitch_out, out_yaw_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [15:0] cfg_data;

  attitude_tracker tracker;
  bit quiet;
  int cfg_writes;

  complementary_attitude_filter_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_rate_x(in_rate_x), .in_rate_y(in_rate_y), .in_rate_z(in_rate_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_roll_out(out_roll_out), .out_pitch_out(out_pitch_out),
    .out_yaw_out(out_yaw_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transfer monitor: results checked before a same-edge sample is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        tracker.check_estimate(out_roll_out, out_pitch_out, out_yaw_out);
      if (in_valid && in_ready)
        tracker.note_sample(in_accel_x, in_accel_y, in_accel_z,
                            in_rate_x, in_rate_y, in_rate_z);
      if (cfg_valid && cfg_ready) begin
        tracker.write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
    end
  end

  // result side back-pressure in random bursts
  always begin
    @(posedge clk);
    if (rst_n && !quiet && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    out_ready <= 1'b1;
  end

  // one sample transfer, with an optional idle burst ahead of it
  task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [15:0] rx, logic [15:0] ry, logic [15:0] rz);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_rate_x <= rx;
    in_rate_y <= ry;
    in_rate_z <= rz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_attitudes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random sample: each field small, full scale or any 16 bit value
  task automatic random_sample();
    logic [15:0] f[6];
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 3))
        0: f[i] = 16'($signed($urandom_range(0, 4000)) - 2000);
        1: f[i] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: f[i] = 16'($urandom);
      endcase
    end
    send_sample(f[0], f[1], f[2], f[3], f[4], f[5]);
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) random_sample();
    drain();
  endtask

  initial begin
    tracker = new();
    quiet = 1'b0;
    cfg_writes = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_accel_x = '0; in_accel_y = '0; in_accel_z = '0;
    in_rate_x = '0; in_rate_y = '0; in_rate_z = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed samples at reset configuration
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'hfc00, 16'h0010, 16'h0010, 16'h0010);
    send_sample(16'h0000, 16'hffff, 16'hfc00, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0400, 16'hfc00, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h4000, 16'h0000, 16'hffff, 16'h0001, 16'hffff);
    send_sample(16'hc000, 16'h8000, 16'h7fff, 16'h5555, 16'haaaa, 16'h5555);
    drain();
    random_run(70);

    // accel angle alone
    write_reg(CFG_GAMMA, 16'd0);
    random_run(60);

    // full gyro weight, longest step: estimates run into saturation
    write_reg(CFG_GAMMA, 16'hffff);
    write_reg(CFG_STEP, 16'hffff);
    random_run(70);

    // no integration; an unknown register index must be ignored
    write_reg(CFG_GAMMA, GAMMA_RST);
    write_reg(CFG_STEP, 16'd0);
    write_reg(8'd2, 16'h1234);
    write_reg(8'hff, 16'hffff);
    random_run(60);

    // random settings
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_GAMMA, 16'($urandom));
      write_reg(CFG_STEP, 16'($urandom));
      random_run(30);
    end

    // back-to-back tail with no idling on either side
    quiet = 1'b1;
    write_reg(CFG_STEP, STEP_RST);
    random_run(40);

    repeat (200) @(posedge clk);
    $display("covered %0d samples and %0d results over %0d register writes",
             tracker.samples, tracker.estimates, cfg_writes);
    $display("settings included zero and full gyro weight, zero and longest step");
    if (tracker.mismatches == 0 && tracker.pending_attitudes.size() == 0) begin
      $display("complementary_attitude_filter_core_tb OK");
    end else begin
      $display("%0d mismatches, %0d results missing", tracker.mismatches,
               tracker.pending_attitudes.size());
      $display("complementary_attitude_filter_core_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("timeout waiting for transfers");
    $display("complementary_attitude_filter_core_tb NOT OK");
    $finish;
  end

endmodule

FILE: complementary_attitude_filter_core.f
rtl/caf_pkg.sv
rtl/caf_digit_mul.sv
rtl/complementary_attitude_filter_core.sv
rtl/caf_checker.sv
verif/complementary_attitude_filter_core_tb.sv
